/* src/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the stepper speed pulse generator
// Holds the item kind, status and register index codes and the divider width.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Width of the shared divider. It holds the half period numerator
  // (30e9 needs 35 bits) and the rounded pot mapping dividend for any ADC
  // width up to 16 bits.
  localparam int unsigned DIV_W     = 35;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [DIV_W-1:0] HALF_PERIOD_NUM = 35'd30000000000;

  typedef enum logic [1:0] {
    ACT_POT  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_CMD  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_UNCHANGED  = 3'd0,
    ST_APPLIED    = 3'd1,
    ST_STOPPED    = 3'd2,
    ST_CLAMP_FAST = 3'd3,
    ST_CLAMP_SLOW = 3'd4,
    ST_INVALID    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_HYSTERESIS = 3'd0,
    REG_DEAD_ZONE  = 3'd1,
    REG_FULL_SCALE = 3'd2,
    REG_STEPS_REV  = 3'd3,
    REG_MIN_HALF   = 3'd4,
    REG_MAX_HALF   = 3'd5
  } cfg_reg_e;

endpackage

/* src/stepper_speed_pulse_generator_top.sv */
// ----------------------------------------------------------------------------
// stepper_speed_pulse_generator_top: stepper step rate generator
// Turns pot samples and speed commands into a STEP square wave and a DIR bit.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel; tuser carries the kind (pot sample,
// one-microsecond tick, speed command) and tdata the ADC reading and the
// commanded speed. Every item yields exactly one result item on m_axis with
// the STEP and DIR levels, the applied speed, the half period and a status.
// Registers are written over the cfg channel, which is always ready; write
// them only while no item is in flight.
// Path through the sequencer: a tick, an ignored pot sample, a rejected
// command or a reserved kind goes straight to the output state, and a command
// that stops the motor passes the speed check first. A command that is applied
// runs one division, an applied pot sample two, or one when its speed falls in
// the dead zone. The work is done by the single restoring divider, which
// delivers one quotient bit per cycle over 35 bits; the pot mapping uses it
// once and the half period once more. One item is worked on at a time:
// s_axis_tready is high only while the sequencer is idle, so the next item is
// accepted in the cycle after the result is loaded at the earliest. A finished
// result sits in the output register while the next item is already accepted;
// if the receiver stalls, the next result waits in the sequencer until the
// output register frees up.
// Reset puts all configuration registers at their defaults, the motor stopped with STEP
// low, DIR clockwise and no pot reading applied yet.
// ----------------------------------------------------------------------------
module stepper_speed_pulse_generator_top #(
  parameter int unsigned ADC_BITS    = 12,
  parameter int unsigned PERIOD_BITS = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [11:0] adc_sample, [29:12] command_mrpm
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [0] step_level, [1] direction_cw,
                                      // [19:2] speed_mrpm, [37:20] half_period_us,
                                      // [40:38] status
);

  localparam int unsigned W = ssp_pkg::DIV_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MAP   = 3'd3;
  localparam logic [2:0] S_SPEED = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [11:0]  RD_MASK  = 12'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [W-1:0] ADC_MAX  = W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [W-1:0] ADC_DIVS = W'(((64'd1 << ADC_BITS) - 64'd1) * 64'd2);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

  // Configuration registers.
  logic [11:0] hyst_q;
  logic [15:0] dead_zone_q;
  logic [16:0] full_scale_q;
  logic [15:0] steps_rev_q;
  logic [17:0] min_half_q;
  logic [17:0] max_half_q;

  // Sequencer and model state.
  logic [2:0]             state_q, state_d;
  logic                   pot_phase_q, pot_phase_d;
  logic [17:0]            opa_q, opa_d;
  logic signed [17:0]     req_q, req_d;
  ssp_pkg::status_e       st_q, st_d;
  logic [11:0]            last_rd_q, last_rd_d;
  logic                   rd_valid_q, rd_valid_d;
  logic signed [17:0]     speed_q, speed_d;
  logic [PERIOD_BITS-1:0] half_q, half_d;
  logic [PERIOD_BITS-1:0] elapsed_q, elapsed_d;
  logic                   step_q, step_d;
  logic                   dir_q, dir_d;
  logic                   m_valid_q, m_valid_d;
  logic [47:0]            m_data_q, m_data_d;

  // Datapath signals.
  ssp_pkg::action_e       action;
  logic [11:0]            reading;
  logic signed [17:0]     cmd;
  logic [11:0]            rd_diff;
  logic signed [18:0]     cmd_ext;
  logic signed [18:0]     fs_ext;
  logic [16:0]            opb;
  logic [W-1:0]           prod;
  logic                   div_start;
  logic [W-1:0]           div_dividend;
  logic [W-1:0]           div_divisor;
  logic                   div_done;
  logic [W-1:0]           quotient;
  logic [18:0]            mapped;
  logic [17:0]            mag;
  logic [17:0]            clamped;
  logic [31:0]            clamped_w;
  logic [PERIOD_BITS-1:0] elapsed_inc;
  logic [31:0]            half_w;
  logic                   accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q       <= 12'd40;
      dead_zone_q  <= 16'd1000;
      full_scale_q <= 17'd60000;
      steps_rev_q  <= 16'd3200;
      min_half_q   <= 18'd100;
      max_half_q   <= 18'd200000;
    end else if (cfg_valid_i) begin
      case (ssp_pkg::cfg_reg_e'(cfg_index_i))
        ssp_pkg::REG_HYSTERESIS: hyst_q       <= cfg_data_i[11:0];
        ssp_pkg::REG_DEAD_ZONE:  dead_zone_q  <= cfg_data_i[15:0];
        ssp_pkg::REG_FULL_SCALE: full_scale_q <= cfg_data_i[16:0];
        ssp_pkg::REG_STEPS_REV:  steps_rev_q  <= cfg_data_i[15:0];
        ssp_pkg::REG_MIN_HALF:   min_half_q   <= cfg_data_i;
        ssp_pkg::REG_MAX_HALF:   max_half_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign action  = ssp_pkg::action_e'(s_axis_tuser);
  assign reading = s_axis_tdata[11:0] & RD_MASK;
  assign cmd     = $signed(s_axis_tdata[29:12]);
  assign rd_diff = (reading > last_rd_q) ? reading - last_rd_q : last_rd_q - reading;
  assign cmd_ext = {cmd[17], cmd};
  assign fs_ext  = $signed({2'b00, full_scale_q});

  // The one multiplier serves the pot scaling (reading times full scale) and
  // the half period divisor (speed magnitude times steps per revolution).
  assign opb  = pot_phase_q ? full_scale_q : {1'b0, steps_rev_q};
  assign prod = W'(opa_q) * W'(opb);

  // The pot mapping rounds half up: (4 * r * full + ADC_MAX) / (2 * ADC_MAX).
  assign div_start    = (state_q == S_MUL);
  assign div_dividend = pot_phase_q ? {prod[W-3:0], 2'b00} + ADC_MAX
                                    : ssp_pkg::HALF_PERIOD_NUM;
  assign div_divisor  = pot_phase_q ? ADC_DIVS : prod;

  ssp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // The scaled value is at most twice the full scale, so 19 bits suffice.
  assign mapped = quotient[18:0] - {2'b00, full_scale_q};
  assign mag    = req_q[17] ? 18'(-req_q) : 18'(req_q);

  // A zero divisor gives an all-ones quotient, which always lands on the
  // slow clamp, as an infinite half period should.
  always_comb begin
    if (quotient < W'(min_half_q)) begin
      clamped = min_half_q;
    end else if (quotient > W'(max_half_q)) begin
      clamped = max_half_q;
    end else begin
      clamped = quotient[17:0];
    end
  end
  assign clamped_w = 32'(clamped);

  assign elapsed_inc = (elapsed_q == PERIOD_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign half_w      = 32'(half_q);

  always_comb begin
    state_d     = state_q;
    pot_phase_d = pot_phase_q;
    opa_d       = opa_q;
    req_d       = req_q;
    st_d        = st_q;
    last_rd_d   = last_rd_q;
    rd_valid_d  = rd_valid_q;
    speed_d     = speed_q;
    half_d      = half_q;
    elapsed_d   = elapsed_q;
    step_d      = step_q;
    dir_d       = dir_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          st_d    = ssp_pkg::ST_UNCHANGED;
          state_d = S_OUT;
          case (action)
            ssp_pkg::ACT_POT: begin
              if (!rd_valid_q || rd_diff > hyst_q) begin
                last_rd_d   = reading;
                rd_valid_d  = 1'b1;
                opa_d       = 18'(reading);
                pot_phase_d = 1'b1;
                state_d     = S_MUL;
              end
            end
            ssp_pkg::ACT_TICK: begin
              if (half_q == '0) begin
                step_d    = 1'b0;
                elapsed_d = elapsed_inc;
              end else if (elapsed_inc >= half_q) begin
                step_d    = !step_q;
                elapsed_d = '0;
              end else begin
                elapsed_d = elapsed_inc;
              end
            end
            ssp_pkg::ACT_CMD: begin
              if (cmd_ext >= -fs_ext && cmd_ext <= fs_ext) begin
                // The pot reference re-syncs to the sample sent along.
                last_rd_d  = reading;
                rd_valid_d = 1'b1;
                req_d      = cmd;
                state_d    = S_SPEED;
              end else begin
                st_d = ssp_pkg::ST_INVALID;
              end
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = pot_phase_q ? S_MAP : S_CLAMP;
        end
      end
      S_MAP: begin
        req_d   = $signed(mapped[17:0]);
        state_d = S_SPEED;
      end
      S_SPEED: begin
        if (mag < 18'(dead_zone_q)) begin
          speed_d = '0;
          half_d  = '0;
          step_d  = 1'b0;
          st_d    = ssp_pkg::ST_STOPPED;
          state_d = S_OUT;
        end else begin
          opa_d       = mag;
          pot_phase_d = 1'b0;
          state_d     = S_MUL;
        end
      end
      S_CLAMP: begin
        if (quotient < W'(min_half_q)) begin
          st_d = ssp_pkg::ST_CLAMP_FAST;
        end else if (quotient > W'(max_half_q)) begin
          st_d = ssp_pkg::ST_CLAMP_SLOW;
        end else begin
          st_d = ssp_pkg::ST_APPLIED;
        end
        half_d  = (clamped_w > 32'(PERIOD_MAX)) ? PERIOD_MAX
                                                : PERIOD_BITS'(clamped_w);
        dir_d   = !req_q[17] && (req_q != '0);
        speed_d = req_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'b0, st_q, half_w[17:0], speed_q, dir_q, step_q};
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pot_phase_q <= 1'b0;
      st_q        <= ssp_pkg::ST_UNCHANGED;
      last_rd_q   <= '0;
      rd_valid_q  <= 1'b0;
      speed_q     <= '0;
      half_q      <= '0;
      elapsed_q   <= '0;
      step_q      <= 1'b0;
      dir_q       <= 1'b1;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pot_phase_q <= pot_phase_d;
      st_q        <= st_d;
      last_rd_q   <= last_rd_d;
      rd_valid_q  <= rd_valid_d;
      speed_q     <= speed_d;
      half_q      <= half_d;
      elapsed_q   <= elapsed_d;
      step_q      <= step_d;
      dir_q       <= dir_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q    <= opa_d;
    req_q    <= req_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // A new result is only ever loaded from the output state.
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

  // A tick while stopped always leaves STEP low.
  a_stopped_tick_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == ssp_pkg::ACT_TICK && half_q == '0) |=> !step_q)
    else $error("STEP high after a tick while stopped");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

/* src/ssp_div.sv */
// ----------------------------------------------------------------------------
// ssp_div: iterative restoring divider
// Produces one quotient bit per cycle; a zero divisor yields all ones.
// ----------------------------------------------------------------------------
module ssp_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ssp_pkg::DIV_W-1:0]    dividend_i,
  input  logic [ssp_pkg::DIV_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [ssp_pkg::DIV_W-1:0]    quotient_o
);

  localparam int unsigned W = ssp_pkg::DIV_W;

  logic [W-1:0]                   dq_q, dq_d;
  logic [W-1:0]                   rem_q, rem_d;
  logic [W-1:0]                   dvs_q, dvs_d;
  logic [ssp_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [W:0]                     shifted;
  logic [W+1:0]                   diff;
  logic                           borrow;

  assign shifted = {rem_q, dq_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign borrow  = diff[W+1];

  always_comb begin
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = ssp_pkg::DIV_CNT_W'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so W bits hold it.
      rem_d = borrow ? shifted[W-1:0] : diff[W-1:0];
      dq_d  = {dq_q[W-2:0], ~borrow};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ssp_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule
